FILE: sv/mpe_pkg.sv
// Package for the phonetic encoder: state and result types, character codes, encode functions.
package mpe_pkg;

  localparam int unsigned NumSlots = 6;

  localparam logic [8:0] END_MARK = 9'h100;

  localparam logic [7:0] LC_A = 8'h61;
  localparam logic [7:0] LC_B = 8'h62;
  localparam logic [7:0] LC_C = 8'h63;
  localparam logic [7:0] LC_D = 8'h64;
  localparam logic [7:0] LC_E = 8'h65;
  localparam logic [7:0] LC_F = 8'h66;
  localparam logic [7:0] LC_G = 8'h67;
  localparam logic [7:0] LC_H = 8'h68;
  localparam logic [7:0] LC_I = 8'h69;
  localparam logic [7:0] LC_J = 8'h6A;
  localparam logic [7:0] LC_K = 8'h6B;
  localparam logic [7:0] LC_L = 8'h6C;
  localparam logic [7:0] LC_M = 8'h6D;
  localparam logic [7:0] LC_N = 8'h6E;
  localparam logic [7:0] LC_O = 8'h6F;
  localparam logic [7:0] LC_P = 8'h70;
  localparam logic [7:0] LC_Q = 8'h71;
  localparam logic [7:0] LC_R = 8'h72;
  localparam logic [7:0] LC_S = 8'h73;
  localparam logic [7:0] LC_T = 8'h74;
  localparam logic [7:0] LC_U = 8'h75;
  localparam logic [7:0] LC_V = 8'h76;
  localparam logic [7:0] LC_W = 8'h77;
  localparam logic [7:0] LC_X = 8'h78;
  localparam logic [7:0] LC_Y = 8'h79;
  localparam logic [7:0] LC_Z = 8'h7A;
  localparam logic [7:0] LC_SP = 8'h20;
  localparam logic [7:0] UC_A = 8'h41;
  localparam logic [7:0] UC_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [6:0] CODE_TH = 7'h30;
  localparam logic [6:0] CODE_X = 7'h58;
  localparam logic [6:0] CODE_K = 7'h4B;
  localparam logic [6:0] CODE_S = 7'h53;
  localparam logic [6:0] CODE_J = 7'h4A;
  localparam logic [6:0] CODE_F = 7'h46;
  localparam logic [6:0] CODE_T = 7'h54;
  localparam logic [6:0] CODE_W = 7'h57;
  localparam logic [6:0] CODE_H = 7'h48;
  localparam logic [6:0] CODE_Y = 7'h59;
  localparam logic [6:0] CODE_B = 7'h42;
  localparam logic [6:0] CODE_L = 7'h4C;
  localparam logic [6:0] CODE_M = 7'h4D;
  localparam logic [6:0] CODE_N = 7'h4E;
  localparam logic [6:0] CODE_R = 7'h52;
  localparam logic [6:0] CODE_P = 7'h50;
  localparam logic [6:0] CODE_SP = 7'h20;

  typedef enum logic [1:0] {
    LEAD_PEND  = 2'd0,
    LEAD_FIRST = 2'd1,
    LEAD_DONE  = 2'd2
  } lead_t;

  typedef struct packed {
    logic [3:0][7:0] win;
    logic [1:0]      skip;
    lead_t           lead;
    logic [1:0]      fill;
  } mpe_state_t;

  typedef struct packed {
    logic [6:0] code_char;
    logic       code_valid;
    logic       end_of_code;
  } res_t;

  typedef struct packed {
    mpe_state_t st;
    logic [1:0] cnt;
    logic [6:0] ch0;
    logic [6:0] ch1;
  } enc_out_t;

  function automatic logic eq9(input logic [8:0] v, input logic [7:0] c);
    return v == {1'b0, c};
  endfunction

  function automatic logic is_vowel(input logic [8:0] v);
    return eq9(v, LC_A) || eq9(v, LC_E) || eq9(v, LC_I) || eq9(v, LC_O) || eq9(v, LC_U);
  endfunction

  function automatic logic soft_next(input logic [8:0] v);
    return eq9(v, LC_I) || eq9(v, LC_E) || eq9(v, LC_Y);
  endfunction

  function automatic logic initial_pair(input logic [7:0] a, input logic [7:0] b);
    return (a == LC_K && b == LC_N) || (a == LC_G && b == LC_N) ||
           (a == LC_P && b == LC_N) || (a == LC_A && b == LC_C) ||
           (a == LC_W && b == LC_R) || (a == LC_A && b == LC_E);
  endfunction

  function automatic mpe_state_t drop_front(input mpe_state_t s);
    mpe_state_t o;
    o        = s;
    o.win[1] = s.win[2];
    o.win[2] = s.win[3];
    o.win[3] = 8'h00;
    o.fill   = (s.fill != 2'd0) ? s.fill - 2'd1 : 2'd0;
    return o;
  endfunction

  // Encode the oldest waiting character and shift the window.
  function automatic enc_out_t encode_one(input mpe_state_t s);
    enc_out_t   o;
    logic [7:0] cur;
    logic [8:0] n1;
    logic [8:0] n2;
    logic [8:0] p;
    logic [8:0] nx;
    logic       first;
    cur      = s.win[1];
    n1       = (s.fill >= 2'd2) ? {1'b0, s.win[2]} : END_MARK;
    n2       = (s.fill == 2'd3) ? {1'b0, s.win[3]} : END_MARK;
    first    = (s.lead == LEAD_FIRST);
    p        = first ? END_MARK : {1'b0, s.win[0]};
    nx       = n1;
    o.st     = drop_front(s);
    o.st.win[0] = cur;
    o.st.lead = LEAD_DONE;
    o.cnt    = 2'd0;
    o.ch0    = 7'h00;
    o.ch1    = 7'h00;
    if (s.skip != 2'd0) begin
      o.st.skip = s.skip - 2'd1;
    end else if (!(eq9(n1, cur) && cur != LC_C)) begin
      unique case (cur) inside
        LC_A, LC_E, LC_I, LC_O, LC_U: begin
          if (first || eq9(p, LC_SP)) begin
            o.cnt = 2'd1;
            o.ch0 = 7'(cur - CASE_OFS);
          end
        end
        LC_B: begin
          if (!(!first && eq9(p, LC_M)) || n1 != END_MARK) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_B;
          end
        end
        LC_C: begin
          o.cnt = 2'd1;
          if ((eq9(n1, LC_I) && eq9(n2, LC_A)) || eq9(n1, LC_H)) begin
            o.ch0     = CODE_X;
            o.st.skip = 2'd1;
          end else if (soft_next(n1)) begin
            o.ch0     = CODE_S;
            o.st.skip = 2'd1;
          end else begin
            o.ch0 = CODE_K;
          end
        end
        LC_D: begin
          o.cnt = 2'd1;
          if (eq9(n1, LC_G) && soft_next(n2)) begin
            o.ch0     = CODE_J;
            o.st.skip = 2'd2;
          end else begin
            o.ch0 = CODE_T;
          end
        end
        LC_F, LC_V: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_F;
        end
        LC_J: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_J;
        end
        LC_L: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_L;
        end
        LC_M: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_M;
        end
        LC_N: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_N;
        end
        LC_Q: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_K;
        end
        LC_R: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_R;
        end
        LC_Z: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_S;
        end
        LC_G: begin
          if (soft_next(n1)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_J;
          end else if (!eq9(n1, LC_H) && !eq9(n1, LC_N)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_K;
          end else if (eq9(n1, LC_H) && n2 != END_MARK && !is_vowel(n2)) begin
            o.st.skip = 2'd1;
          end else if (!eq9(n1, LC_N)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_K;
          end
        end
        LC_H: begin
          if (first || is_vowel(n1) || is_vowel(p)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_H;
          end
        end
        LC_K: begin
          if (first || !eq9(p, LC_C)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_K;
          end
        end
        LC_P: begin
          o.cnt = 2'd1;
          if (eq9(n1, LC_H)) begin
            o.ch0     = CODE_F;
            o.st.skip = 2'd1;
          end else begin
            o.ch0 = CODE_P;
          end
        end
        LC_S: begin
          o.cnt = 2'd1;
          if (eq9(n1, LC_H)) begin
            o.ch0     = CODE_X;
            o.st.skip = 2'd1;
          end else if (eq9(n1, LC_I) && (eq9(n2, LC_O) || eq9(n2, LC_A))) begin
            o.ch0     = CODE_X;
            o.st.skip = 2'd2;
          end else begin
            o.ch0 = CODE_S;
          end
        end
        LC_T: begin
          if (eq9(n1, LC_I) && (eq9(n2, LC_A) || eq9(n2, LC_O))) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_X;
          end else if (eq9(n1, LC_H)) begin
            o.cnt     = 2'd1;
            o.ch0     = CODE_TH;
            o.st.skip = 2'd1;
          end else if (!eq9(n1, LC_C) || !eq9(n2, LC_H)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_T;
          end
        end
        LC_W: begin
          if (first && eq9(n1, LC_H)) begin
            o.st.skip = 2'd1;
            nx        = n2;
          end
          if (is_vowel(nx)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_W;
          end
        end
        LC_X: begin
          if (first) begin
            o.cnt = 2'd1;
            if (eq9(n1, LC_H) || (eq9(n1, LC_I) && (eq9(n2, LC_O) || eq9(n2, LC_A)))) begin
              o.ch0 = CODE_X;
            end else begin
              o.ch0 = CODE_S;
            end
          end else begin
            o.cnt = 2'd2;
            o.ch0 = CODE_K;
            o.ch1 = CODE_S;
          end
        end
        LC_Y: begin
          if (is_vowel(n1)) begin
            o.cnt = 2'd1;
            o.ch0 = CODE_Y;
          end
        end
        LC_SP: begin
          o.cnt = 2'd1;
          o.ch0 = CODE_SP;
        end
        default: begin
          o.cnt = 2'd0;
        end
      endcase
    end
    return o;
  endfunction

endpackage

FILE: sv/mpe_in_if.sv
// Input channel: one character beat with its end-of-word flag.
interface mpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

FILE: sv/mpe_out_if.sv
// Result channel: one code character beat.
interface mpe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_char;
  logic       code_valid;
  logic       end_of_code;

  modport source (output valid, output code_char, output code_valid, output end_of_code,
                  input ready);
  modport sink (input valid, input code_char, input code_valid, input end_of_code,
                output ready);
endinterface

FILE: sv/mpe_step.sv
// Per-character step: window update, initial pair test and up to three encodes into six slots.
module mpe_step (
  input  mpe_pkg::mpe_state_t                     st,
  input  logic [7:0]                              char_in,
  input  logic                                    last_char,
  output mpe_pkg::mpe_state_t                     st_nxt,
  output mpe_pkg::res_t [mpe_pkg::NumSlots-1:0]   slots,
  output logic [mpe_pkg::NumSlots-1:0]            mask
);

  logic [7:0]          c;
  mpe_pkg::mpe_state_t s;
  mpe_pkg::enc_out_t   e1;
  mpe_pkg::enc_out_t   e2;
  mpe_pkg::enc_out_t   e3;
  logic [2:0]          last_idx;

  always_comb begin
    c = char_in;
    if (c >= mpe_pkg::UC_A && c <= mpe_pkg::UC_Z) begin
      c = c + mpe_pkg::CASE_OFS;
    end
    s = st;
    case (st.fill)
      2'd0:    s.win[1] = c;
      2'd1:    s.win[2] = c;
      default: s.win[3] = c;
    endcase
    s.fill = st.fill + 2'd1;
    if (st.lead == mpe_pkg::LEAD_PEND && (s.fill == 2'd2 || last_char)) begin
      if (s.fill == 2'd2 && mpe_pkg::initial_pair(s.win[1], s.win[2])) begin
        s = mpe_pkg::drop_front(s);
      end
      s.lead = mpe_pkg::LEAD_FIRST;
    end
  end

  always_comb begin
    e1 = mpe_pkg::encode_one(s);
    e2 = mpe_pkg::encode_one(e1.st);
    e3 = mpe_pkg::encode_one(e2.st);
  end

  always_comb begin
    slots[0] = '{code_char: e1.ch0, code_valid: 1'b1, end_of_code: 1'b0};
    slots[1] = '{code_char: e1.ch1, code_valid: 1'b1, end_of_code: 1'b0};
    slots[2] = '{code_char: e2.ch0, code_valid: 1'b1, end_of_code: 1'b0};
    slots[3] = '{code_char: e2.ch1, code_valid: 1'b1, end_of_code: 1'b0};
    slots[4] = '{code_char: e3.ch0, code_valid: 1'b1, end_of_code: 1'b0};
    slots[5] = '{code_char: e3.ch1, code_valid: 1'b1, end_of_code: 1'b0};
    mask     = '0;
    st_nxt   = s;
    last_idx = 3'd0;
    if (last_char) begin
      mask[0] = (e1.cnt != 2'd0);
      mask[1] = (e1.cnt == 2'd2);
      if (e1.st.fill != 2'd0) begin
        mask[2] = (e2.cnt != 2'd0);
        mask[3] = (e2.cnt == 2'd2);
      end
      if (e1.st.fill != 2'd0 && e2.st.fill != 2'd0) begin
        mask[4] = (e3.cnt != 2'd0);
        mask[5] = (e3.cnt == 2'd2);
      end
      st_nxt = '0;
      for (int i = 0; i < mpe_pkg::NumSlots; i++) begin
        if (mask[i]) begin
          last_idx = 3'(i);
        end
      end
      if (mask != '0) begin
        slots[last_idx].end_of_code = 1'b1;
      end else begin
        // empty code: one marker beat
        slots[0] = '{code_char: 7'h00, code_valid: 1'b0, end_of_code: 1'b1};
        mask[0]  = 1'b1;
      end
    end else if (s.fill == 2'd3) begin
      mask[0] = (e1.cnt != 2'd0);
      mask[1] = (e1.cnt == 2'd2);
      st_nxt  = e1.st;
    end
  end

endmodule

FILE: sv/metaphone_phonetic_encoder.sv
// Top level of the phonetic encoder: state register, result slot buffer and handshakes.
// Usage:
//   in_ch carries one character beat per handshake (char_in, last_char on the final
//   character of a word). Upper-case letters are folded to lower case.
//   out_ch carries the code, one character per beat; end_of_code marks the final
//   beat of a word. A word with no code gives one beat with code_valid low.
//   Two lookahead characters are held back, so a character's code leaves two beats
//   later; the last_char beat flushes the rest of the word (up to six results).
//   Latency: results of an accepted beat are on out_ch the next cycle.
//   Throughput: one input beat per cycle while each beat releases at most one
//   result and out_ch is ready; a beat that releases more holds the input until
//   only one of its results is left (two results per character at most, up to six
//   on last_char), set by the single result port draining the six-slot buffer.
//   in_ch.ready is high when no result is queued, or one is and it leaves this
//   cycle; a stalled out_ch holds its beat and blocks input until drained.
//   Reset clears the window, the skip count and the word position, and empties the buffer.
module metaphone_phonetic_encoder (
  input logic      clk,
  input logic      rst_n,
  mpe_in_if.sink   in_ch,
  mpe_out_if.source out_ch
);

  mpe_pkg::mpe_state_t                   st_r;
  mpe_pkg::mpe_state_t                   st_nxt;
  mpe_pkg::res_t [mpe_pkg::NumSlots-1:0] slot_r;
  mpe_pkg::res_t [mpe_pkg::NumSlots-1:0] step_slots;
  logic [mpe_pkg::NumSlots-1:0]          mask_r;
  logic [mpe_pkg::NumSlots-1:0]          mask_nxt;
  logic [mpe_pkg::NumSlots-1:0]          step_mask;
  logic [2:0]                            sel;
  logic                                  found;
  logic                                  in_acc;
  logic                                  out_acc;

  mpe_step u_step (
    .st        (st_r),
    .char_in   (in_ch.char_in),
    .last_char (in_ch.last_char),
    .st_nxt    (st_nxt),
    .slots     (step_slots),
    .mask      (step_mask)
  );

  always_comb begin
    sel   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < mpe_pkg::NumSlots; i++) begin
      if (mask_r[i] && !found) begin
        sel   = 3'(i);
        found = 1'b1;
      end
    end
  end

  assign out_ch.valid       = found;
  assign out_ch.code_char   = slot_r[sel].code_char;
  assign out_ch.code_valid  = slot_r[sel].code_valid;
  assign out_ch.end_of_code = slot_r[sel].end_of_code;

  assign in_ch.ready = ((mask_r & (mask_r - 6'd1)) == '0) && (!found || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  always_comb begin
    mask_nxt = mask_r;
    if (in_acc) begin
      mask_nxt = step_mask;
    end else if (out_acc) begin
      mask_nxt[sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (in_acc) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= step_slots;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_char |=>
      (st_r.fill == 2'd0 && st_r.lead == mpe_pkg::LEAD_PEND && mask_r != '0))
    else $error("word end did not clear state or queue results");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fill != 2'd3)
    else $error("window holds three waiting characters between beats");

  a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !in_acc |=> $countones(mask_r) == $countones($past(mask_r)) - 1)
    else $error("result beat did not retire exactly one slot");

  a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_code |-> $onehot(mask_r))
    else $error("end of code shown with results still queued");
`endif

endmodule
